>>> rtl/core/dll_pkg.sv
// Shared definitions for the doubly linked list manager.
// Action codes, decoded operation kinds, controller states and the default pool size.
// No dependencies.
package dll_pkg;

  localparam int DLL_NODE_POOL = 256;
  localparam int ACT_W         = 3;

  // Action codes carried on the input channel
  localparam logic [ACT_W-1:0] ACT_INS_AFTER = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_HEAD  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_TAIL  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REM_NODE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REM_HEAD  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REM_TAIL  = 3'd5;

  // Operation after decode: what the link update really does
  typedef enum logic [2:0] {
    K_NOP   = 3'd0,
    K_HEAD  = 3'd1,
    K_TAIL  = 3'd2,
    K_AFTER = 3'd3,
    K_TAKE  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WR1  = 3'b010,
    ST_WR2  = 3'b100
  } state_t;

endpackage

>>> rtl/core/doubly_linked_list_manager.sv
// Top level of the doubly linked list manager: controller, head/tail/count registers.
// Uses dll_pkg and two dll_link_ram instances (next links, previous links).
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready | action, node_index, after_index
//   out     | output    | out_valid/out_ready | removed_index, head_index, tail_index,
//           |           |                     | entry_count
//
// Links are read at the accept edge, the first write of each link memory goes out in the
// next cycle (ST_WR1), and the second write goes out and the result is registered in
// ST_WR2. Both link memories have one write port, so an action needing two writes per
// memory needs both write states. A new item is accepted once the controller is back in
// idle. A stalled output holds the controller in its last write cycle (the write repeats
// harmlessly). Reset empties the list at once; the link memories are not cleared.
module doubly_linked_list_manager
  import dll_pkg::*;
#(
  parameter int NODE_POOL = DLL_NODE_POOL,
  localparam int IW = $clog2(NODE_POOL),
  localparam int LW = $clog2(NODE_POOL + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] action,
  input  logic [IW-1:0]    node_index,
  input  logic [LW-1:0]    after_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LW-1:0]    removed_index,
  output logic [LW-1:0]    head_index,
  output logic [LW-1:0]    tail_index,
  output logic [LW-1:0]    entry_count
);

  localparam logic [LW-1:0] NIL = LW'(NODE_POOL);

  state_t        state;
  kind_t         kind;
  logic [LW-1:0] op_node;
  logic [LW-1:0] op_pre;
  logic [LW-1:0] head;
  logic [LW-1:0] tail;
  logic [LW-1:0] count;
  logic [LW-1:0] removed;

  // second write of each memory, held for the last write cycle
  logic          nb_en, pb_en;
  logic [IW-1:0] nb_addr, pb_addr;
  logic [LW-1:0] nb_data, pb_data;

  logic          accept;
  logic          out_load;
  kind_t         kind_next;
  logic [LW-1:0] node_ext, pre_n, sel_node, rd_addr, removed_next;
  logic          node_ok;

  logic [LW-1:0] next_rdata, prev_rdata, rn, rp;
  logic          na_en, pa_en, nb_en_next, pb_en_next;
  logic [LW-1:0] na_addr, pa_addr, nb_addr_next, pb_addr_next;
  logic [LW-1:0] na_data, pa_data, nb_data_next, pb_data_next;
  logic [LW-1:0] head_next, tail_next, count_next, count_up, count_down;
  logic          empty;

  logic          nwe, pwe;
  logic [IW-1:0] nwaddr, pwaddr;
  logic [LW-1:0] nwdata, pwdata;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign out_load = (state == ST_WR2) && (!out_valid || out_ready);

  // ---- decode at accept ----
  assign node_ext = LW'(node_index);
  assign node_ok  = node_ext < NIL;
  assign pre_n    = (after_index < NIL) ? after_index : NIL;

  always_comb begin
    kind_next    = K_NOP;
    sel_node     = node_ext;
    removed_next = NIL;
    case (action)
      ACT_INS_AFTER: begin
        if (node_ok) begin
          kind_next = ((count == '0) || (pre_n == NIL)) ? K_HEAD : K_AFTER;
        end
      end
      ACT_INS_HEAD: if (node_ok) kind_next = K_HEAD;
      ACT_INS_TAIL: if (node_ok) kind_next = K_TAIL;
      ACT_REM_NODE: begin
        if (node_ok) begin
          kind_next    = K_TAKE;
          removed_next = node_ext;
        end
      end
      ACT_REM_HEAD: begin
        sel_node = head;
        if (head != NIL) begin
          kind_next    = K_TAKE;
          removed_next = head;
        end
      end
      ACT_REM_TAIL: begin
        sel_node = tail;
        if (tail != NIL) begin
          kind_next    = K_TAKE;
          removed_next = tail;
        end
      end
      default: kind_next = K_NOP;
    endcase
  end

  // insert-after looks up the predecessor's successor; remove looks up the node itself
  assign rd_addr = (kind_next == K_AFTER) ? pre_n : sel_node;

  // ---- link updates, computed in the first write cycle ----
  assign rn    = (next_rdata < NIL) ? next_rdata : NIL;
  assign rp    = (prev_rdata < NIL) ? prev_rdata : NIL;
  assign empty = (count == '0);
  assign count_up   = (count < NIL) ? count + 1'b1 : count;
  assign count_down = empty ? count : count - 1'b1;

  always_comb begin
    na_en = 1'b0;  na_addr = op_node;  na_data = NIL;
    pa_en = 1'b0;  pa_addr = op_node;  pa_data = NIL;
    nb_en_next = 1'b0;  nb_addr_next = op_node;  nb_data_next = NIL;
    pb_en_next = 1'b0;  pb_addr_next = op_node;  pb_data_next = NIL;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    case (kind)
      K_HEAD: begin
        na_en        = 1'b1;
        na_data      = head;
        pa_en        = 1'b1;
        pb_en_next   = !empty && (head != NIL);
        pb_addr_next = head;
        pb_data_next = op_node;
        head_next    = op_node;
        if (empty) tail_next = op_node;
        count_next   = count_up;
      end
      K_TAIL: begin
        na_en        = 1'b1;
        nb_en_next   = !empty && (tail != NIL);
        nb_addr_next = tail;
        nb_data_next = op_node;
        pa_en        = 1'b1;
        pa_data      = tail;
        tail_next    = op_node;
        if (empty) head_next = op_node;
        count_next   = count_up;
      end
      K_AFTER: begin
        na_en        = 1'b1;
        na_data      = rn;
        nb_en_next   = 1'b1;
        nb_addr_next = op_pre;
        nb_data_next = op_node;
        pa_en        = 1'b1;
        pa_data      = op_pre;
        pb_en_next   = (rn != NIL);
        pb_addr_next = rn;
        pb_data_next = op_node;
        if (tail == op_pre) tail_next = op_node;
        count_next   = count_up;
      end
      K_TAKE: begin
        // bridge the neighbors first, then clear the node's own links
        na_en      = (rp != NIL);
        na_addr    = rp;
        na_data    = rn;
        nb_en_next = 1'b1;
        pa_en      = (rn != NIL);
        pa_addr    = rn;
        pa_data    = rp;
        pb_en_next = 1'b1;
        if (op_node == head) head_next = rn;
        if (op_node == tail) tail_next = rp;
        count_next = count_down;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // ---- memory write muxing ----
  always_comb begin
    nwe    = 1'b0;
    pwe    = 1'b0;
    nwaddr = na_addr[IW-1:0];
    nwdata = na_data;
    pwaddr = pa_addr[IW-1:0];
    pwdata = pa_data;
    unique case (state)
      ST_WR1: begin
        nwe = na_en;
        pwe = pa_en;
      end
      ST_WR2: begin
        nwe    = nb_en;
        nwaddr = nb_addr;
        nwdata = nb_data;
        pwe    = pb_en;
        pwaddr = pb_addr;
        pwdata = pb_data;
      end
      default: begin
        nwe = 1'b0;
        pwe = 1'b0;
      end
    endcase
  end

  dll_link_ram #(.DEPTH(NODE_POOL), .AW(IW), .DW(LW)) u_next_ram (
    .clk   (clk),
    .we    (nwe),
    .waddr (nwaddr),
    .wdata (nwdata),
    .re    (accept),
    .raddr (rd_addr[IW-1:0]),
    .rdata (next_rdata)
  );

  dll_link_ram #(.DEPTH(NODE_POOL), .AW(IW), .DW(LW)) u_prev_ram (
    .clk   (clk),
    .we    (pwe),
    .waddr (pwaddr),
    .wdata (pwdata),
    .re    (accept),
    .raddr (rd_addr[IW-1:0]),
    .rdata (prev_rdata)
  );

  // ---- control and list registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      kind      <= K_NOP;
      head      <= NIL;
      tail      <= NIL;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            kind  <= kind_next;
            state <= ST_WR1;
          end
        end
        ST_WR1: begin
          head  <= head_next;
          tail  <= tail_next;
          count <= count_next;
          state <= ST_WR2;
        end
        ST_WR2: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (accept) begin
      op_node <= sel_node;
      op_pre  <= pre_n;
      removed <= removed_next;
    end
    if (state == ST_WR1) begin
      nb_en   <= nb_en_next;
      nb_addr <= nb_addr_next[IW-1:0];
      nb_data <= nb_data_next;
      pb_en   <= pb_en_next;
      pb_addr <= pb_addr_next[IW-1:0];
      pb_data <= pb_data_next;
    end
    if (out_load) begin
      removed_index <= removed;
      head_index    <= head;
      tail_index    <= tail;
      entry_count   <= count;
    end
  end

endmodule

>>> rtl/core/dll_link_ram.sv
// One link memory (next or previous links) of the list manager.
// One write port, one read port, registered read data, no reset on the array.
// No package dependencies.
module dll_link_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
